@@ src/aft_pkg.sv @@
package aft_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W     = 64;
    localparam int STAMP_W   = 64;
    localparam int COUNT_W   = 6;
    localparam int FUNC_W    = 2;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = KEY_W + 1 + STAMP_W + STAMP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + 1 + STAMP_W + 1 + 1 + KEY_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_ERASE   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEANUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               done;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

@@ src/aging_flag_table_unit.sv @@
// Aging flag table: a bounded associative table of aft_pkg::ENTRIES slots that
// maps a 64-bit key to a done flag and a millisecond stamp.
//
// Requests enter on the s_* stream (s_tuser carries the operation: insert,
// erase, query, cleanup); exactly one response per request leaves on m_*.
// Key, flag and stamp live in a single-port-write synchronous RAM with a
// registered read; per-slot valid bits sit in flip-flops.
//
// Every request sweeps the RAM once, one slot per cycle, collecting the key
// match, the lowest free slot, the oldest stamp and the stale entries. A
// request passes from acceptance through the scan state (one read per slot),
// the drain state (which empties the RAM read register) and the apply state
// (write-back and the response register). The next request is taken only in
// the idle state after the apply state. The sweep length is set by the single
// RAM read port. One request is in flight at a time.
//
// Reset clears all valid bits at once, so the table is empty right after
// reset; an invalid slot's RAM contents never decide a response. A stalled
// receiver holds the response in the output register; the block still accepts
// and sweeps the next request, and holds its write-back until the output is free.
module aging_flag_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_key[63:0], flag_in[64], now_ms[128:65], max_age_ms[192:129], zero pad
    input  logic [aft_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [aft_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit[0], flag_out[1], stamp_out[65:2], status[66], evicted[67],
    // evicted_key[131:68], removed_count[137:132], zero pad
    output logic [aft_pkg::M_TDATA_W-1:0] m_tdata
);
    import aft_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    // Request held for the whole sweep
    op_t                req_func_reg, req_func_next;
    logic [KEY_W-1:0]   req_key_reg, req_key_next;
    logic               req_flag_reg, req_flag_next;
    logic [STAMP_W-1:0] req_now_reg, req_now_next;
    logic [STAMP_W-1:0] req_age_reg, req_age_next;

    // Sweep address and evaluation stage
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;

    // Sweep findings
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               match_done_reg, match_done_next;
    logic [STAMP_W-1:0] match_stamp_reg, match_stamp_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic [KEY_W-1:0]   old_key_reg, old_key_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Slot RAM
    entry_t             mem [ENTRIES];
    entry_t             mem_rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    entry_t             mem_wd;

    logic               s_accept;
    logic               apply_go;
    logic               scan_rd;

    // Response fields
    logic               r_hit;
    logic               r_flag;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_status;
    logic               r_evicted;
    logic [KEY_W-1:0]   r_evicted_key;
    logic [COUNT_W-1:0] r_removed;
    logic [IDX_W-1:0]   ins_idx;

    logic               ev_valid;
    logic [STAMP_W-1:0] ev_age;

    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        scan_rd  = 1'b0;
        apply_go = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  scan_rd  = 1'b1;
            ST_DRAIN: scan_rd  = 1'b0;
            ST_APPLY: apply_go = !m_tvalid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    // Memory: read the swept slot, write back on apply. Reads and the write
    // never target the same cycle of one request, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[cnt_reg];
    end

    assign ev_valid = valid_reg[ev_idx_reg];
    assign ev_age   = req_now_reg - mem_rd_reg.stamp;
    assign ins_idx  = free_found_reg ? free_idx_reg : old_idx_reg;

    // Datapath
    always_comb
    begin
        req_func_next    = req_func_reg;
        req_key_next     = req_key_reg;
        req_flag_next    = req_flag_reg;
        req_now_next     = req_now_reg;
        req_age_next     = req_age_reg;
        cnt_next         = cnt_reg;
        ev_vld_next      = scan_rd;
        ev_idx_next      = cnt_reg;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_done_next  = match_done_reg;
        match_stamp_next = match_stamp_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        old_idx_next     = old_idx_reg;
        old_stamp_next   = old_stamp_reg;
        old_key_next     = old_key_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        mem_wa           = match_idx_reg;
        mem_wd           = '{key: req_key_reg, done: req_flag_reg, stamp: req_now_reg};
        r_hit            = 1'b0;
        r_flag           = 1'b0;
        r_stamp          = '0;
        r_status         = 1'b0;
        r_evicted        = 1'b0;
        r_evicted_key    = '0;
        r_removed        = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Latch the request and clear the findings
        if (s_accept)
        begin
            req_func_next   = op_t'(s_tuser);
            req_key_next    = s_tdata[KEY_W-1:0];
            req_flag_next   = s_tdata[KEY_W];
            req_now_next    = s_tdata[KEY_W+STAMP_W:KEY_W+1];
            req_age_next    = s_tdata[KEY_W+2*STAMP_W:KEY_W+STAMP_W+1];
            cnt_next        = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            count_next      = '0;
        end

        // Advance the sweep address
        if (scan_rd && (cnt_reg != LAST_IDX))
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        // Evaluate one slot
        if (ev_vld_reg)
        begin
            if (ev_valid && (mem_rd_reg.key == req_key_reg) && !found_reg)
            begin
                found_next       = 1'b1;
                match_idx_next   = ev_idx_reg;
                match_done_next  = mem_rd_reg.done;
                match_stamp_next = mem_rd_reg.stamp;
            end
            if (!ev_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ev_idx_reg;
            end
            // Oldest stamp, ties to the lowest slot
            if ((ev_idx_reg == '0) || (mem_rd_reg.stamp < old_stamp_reg))
            begin
                old_idx_next   = ev_idx_reg;
                old_stamp_next = mem_rd_reg.stamp;
                old_key_next   = mem_rd_reg.key;
            end
            if ((req_func_reg == OP_CLEANUP) && ev_valid && (ev_age > req_age_reg))
            begin
                valid_next[ev_idx_reg] = 1'b0;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        // Resolve the request
        case (req_func_reg)
            OP_INSERT:
            begin
                if (req_key_reg == '0)
                begin
                    r_status = 1'b1;
                end
                else if (found_reg)
                begin
                    r_hit  = 1'b1;
                    mem_we = apply_go && req_flag_reg;
                    mem_wa = match_idx_reg;
                end
                else
                begin
                    r_evicted     = !free_found_reg;
                    r_evicted_key = free_found_reg ? '0 : old_key_reg;
                    mem_we        = apply_go;
                    mem_wa        = ins_idx;
                    if (apply_go)
                    begin
                        valid_next[ins_idx] = 1'b1;
                    end
                end
            end
            OP_ERASE:
            begin
                if (found_reg)
                begin
                    r_hit     = 1'b1;
                    r_removed = COUNT_W'(1);
                    if (apply_go)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                    end
                end
            end
            OP_QUERY:
            begin
                r_hit   = found_reg;
                r_flag  = found_reg ? match_done_reg : 1'b1;
                r_stamp = found_reg ? match_stamp_reg : '0;
            end
            OP_CLEANUP:
            begin
                r_removed = count_reg;
            end
            default:
            begin
                r_removed = '0;
            end
        endcase

        // Load the response register
        if (apply_go)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({r_removed, r_evicted_key, r_evicted, r_status,
                                        r_stamp, r_flag, r_hit});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            ev_vld_reg   <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            ev_vld_reg   <= ev_vld_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_func_reg    <= req_func_next;
        req_key_reg     <= req_key_next;
        req_flag_reg    <= req_flag_next;
        req_now_reg     <= req_now_next;
        req_age_reg     <= req_age_next;
        ev_idx_reg      <= ev_idx_next;
        found_reg       <= found_next;
        match_idx_reg   <= match_idx_next;
        match_done_reg  <= match_done_next;
        match_stamp_reg <= match_stamp_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        old_idx_reg     <= old_idx_next;
        old_stamp_reg   <= old_stamp_next;
        old_key_reg     <= old_key_next;
        count_reg       <= count_next;
        m_tdata_reg     <= m_tdata_next;
    end

endmodule

@@ tb/sv/tb_aging_flag_table_unit.sv @@
module tb_aging_flag_table_unit;

    import aft_pkg::*;

    localparam int POOL_SIZE = 40;
    localparam logic [63:0] ALL_ONES = '1;

    // Request fields as they sit in s_tdata, key in the low bits
    typedef struct packed {
        logic [STAMP_W-1:0] max_age;
        logic [STAMP_W-1:0] now;
        logic               flag;
        logic [KEY_W-1:0]   key;
    } req_t;

    // Response fields as they sit in m_tdata, hit in bit 0
    typedef struct packed {
        logic [COUNT_W-1:0] removed;
        logic [KEY_W-1:0]   ev_key;
        logic               evicted;
        logic               status;
        logic [STAMP_W-1:0] stamp;
        logic               flag;
        logic               hit;
    } resp_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Mirror of the table contents, updated once per accepted request
    logic         tbl_valid [ENTRIES];
    logic [63:0]  tbl_key   [ENTRIES];
    logic         tbl_done  [ENTRIES];
    logic [63:0]  tbl_stamp [ENTRIES];

    resp_t        expected_resps[$];
    int           fail_count = 0;
    int           mismatch_count = 0;
    bit           idle_on = 1'b1;
    logic [63:0]  key_pool [POOL_SIZE];
    logic [63:0]  clock_ms = '0;

    aging_flag_table_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one request to the mirrored table and return the response it
    // must produce. One sweep finds the matching slot, the lowest free slot
    // and the oldest stamp (lowest slot wins a tie), as the block does.
    function automatic resp_t table_apply(op_t op, req_t rq);
        resp_t       r;
        int          i;
        int          match;
        int          free_idx;
        int          oldest;
        logic [63:0] age;
        r        = '0;
        match    = -1;
        free_idx = -1;
        oldest   = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == rq.key && match < 0)
                match = i;
            if (!tbl_valid[i] && free_idx < 0)
                free_idx = i;
            if (tbl_stamp[i] < tbl_stamp[oldest])
                oldest = i;
        end
        case (op)
            OP_INSERT:
            begin
                if (rq.key == '0)
                    r.status = 1'b1;
                else if (match >= 0)
                begin
                    // Present key: pending leaves it alone, done restamps it
                    r.hit = 1'b1;
                    if (rq.flag)
                    begin
                        tbl_done[match]  = 1'b1;
                        tbl_stamp[match] = rq.now;
                    end
                end
                else
                begin
                    // Absent key: take the lowest free slot, else evict oldest
                    if (free_idx < 0)
                    begin
                        free_idx  = oldest;
                        r.evicted = 1'b1;
                        r.ev_key  = tbl_key[oldest];
                    end
                    tbl_valid[free_idx] = 1'b1;
                    tbl_key[free_idx]   = rq.key;
                    tbl_done[free_idx]  = rq.flag;
                    tbl_stamp[free_idx] = rq.now;
                end
            end
            OP_ERASE:
            begin
                if (match >= 0)
                begin
                    r.hit            = 1'b1;
                    r.removed        = COUNT_W'(1);
                    tbl_valid[match] = 1'b0;
                end
            end
            OP_QUERY:
            begin
                if (match >= 0)
                begin
                    r.hit   = 1'b1;
                    r.flag  = tbl_done[match];
                    r.stamp = tbl_stamp[match];
                end
                else
                    r.flag = 1'b1;
            end
            default:
            begin
                // Age wraps modulo 2^64; drop only when strictly older
                for (i = 0; i < ENTRIES; i++)
                begin
                    age = rq.now - tbl_stamp[i];
                    if (tbl_valid[i] && age > rq.max_age)
                    begin
                        tbl_valid[i] = 1'b0;
                        if (r.removed != COUNT_MAX)
                            r.removed = r.removed + 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Drive one request after a random gap and hold it until the block
    // takes the transaction. Leave tvalid high on return so that a request
    // sent right behind it never drops and raises tvalid in one step.
    task automatic issue_request(op_t op, logic [63:0] key, logic flag,
                                 logic [63:0] now, logic [63:0] max_age);
        req_t rq;
        int   gap;
        rq.key     = key;
        rq.flag    = flag;
        rq.now     = now;
        rq.max_age = max_age;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, rq};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        expected_resps.push_back(table_apply(op, rq));
    endtask

    // Response side: compare each transaction with the oldest expectation,
    // then pick the next ready level with random stalls.
    int rx_hold = 0;
    always @(posedge clk)
    begin : rx_side
        resp_t got;
        resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[M_FIELDS_W-1:0];
            if (expected_resps.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response transaction %h", got);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (got.hit !== want.hit || got.flag !== want.flag
                    || got.stamp !== want.stamp || got.status !== want.status
                    || got.evicted !== want.evicted || got.ev_key !== want.ev_key
                    || got.removed !== want.removed)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("exp hit=%0d flag=%0d stamp=%h st=%0d ev=%0d evkey=%h rm=%0d",
                                 want.hit, want.flag, want.stamp, want.status,
                                 want.evicted, want.ev_key, want.removed);
                        $display("got hit=%0d flag=%0d stamp=%h st=%0d ev=%0d evkey=%h rm=%0d",
                                 got.hit, got.flag, got.stamp, got.status,
                                 got.evicted, got.ev_key, got.removed);
                    end
                end
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold != 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    // Empty table, zero key on every operation, cleanup with nothing in it
    task automatic test_empty_and_zero_key();
        issue_request(OP_QUERY, '0, 1'b0, '0, '0);
        issue_request(OP_QUERY, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES);
        issue_request(OP_INSERT, '0, 1'b1, 64'd10, '0);
        issue_request(OP_INSERT, '0, 1'b0, 64'd11, '0);
        issue_request(OP_ERASE, '0, 1'b0, 64'd12, '0);
        issue_request(OP_CLEANUP, '0, 1'b0, 64'd13, '0);
    endtask

    // Pending insert never touches a present key; done insert restamps it
    task automatic test_insert_query_erase();
        issue_request(OP_INSERT, ALL_ONES, 1'b0, 64'd100, '0);
        issue_request(OP_INSERT, ALL_ONES, 1'b0, 64'd200, '0);
        issue_request(OP_QUERY, ALL_ONES, 1'b0, 64'd201, '0);
        issue_request(OP_INSERT, ALL_ONES, 1'b1, ALL_ONES, '0);
        issue_request(OP_QUERY, ALL_ONES, 1'b0, 64'd202, '0);
        issue_request(OP_INSERT, 64'd1, 1'b1, '0, '0);
        issue_request(OP_QUERY, 64'd1, 1'b0, 64'd203, '0);
        issue_request(OP_ERASE, ALL_ONES, 1'b0, 64'd204, '0);
        issue_request(OP_ERASE, ALL_ONES, 1'b0, 64'd205, '0);
        issue_request(OP_QUERY, ALL_ONES, 1'b0, 64'd206, '0);
    endtask

    // Age exactly at the limit stays; wrapped ages count as huge
    task automatic test_cleanup_ages();
        issue_request(OP_INSERT, 64'd2, 1'b0, 64'd50, '0);
        issue_request(OP_INSERT, 64'd3, 1'b0, 64'd10, '0);
        issue_request(OP_CLEANUP, '0, 1'b0, 64'd50, 64'd40);
        issue_request(OP_CLEANUP, '0, 1'b0, 64'd5, ALL_ONES);
        issue_request(OP_CLEANUP, '0, 1'b0, 64'd5, '0);
    endtask

    // Fill every slot, then evict: equal oldest stamps go to the lower slot,
    // a maximal stamp can still be the victim once it is the smallest.
    task automatic test_full_table();
        int i;
        logic [63:0] stamp;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (i == 5 || i == 9)
                stamp = 64'd7;
            else if (i == ENTRIES - 1)
                stamp = ALL_ONES;
            else
                stamp = 64'd1000 + 64'(i);
            issue_request(OP_INSERT, 64'h100 + 64'(i), i[0], stamp, '0);
        end
        issue_request(OP_INSERT, 64'h500, 1'b0, 64'd2000, '0);
        issue_request(OP_INSERT, 64'h501, 1'b1, 64'd2001, '0);
        issue_request(OP_INSERT, 64'h100, 1'b1, 64'd3, '0);
        issue_request(OP_INSERT, 64'h502, 1'b0, 64'd2002, '0);
        issue_request(OP_ERASE, 64'h10A, 1'b0, 64'd2003, '0);
        issue_request(OP_INSERT, 64'h503, 1'b1, 64'd2004, '0);
        // Raise every stamp but one to the max so it becomes the only victim
        for (i = 0; i < ENTRIES; i++)
            if (i != 3)
                issue_request(OP_INSERT, tbl_key[i], 1'b1, ALL_ONES, '0);
        issue_request(OP_INSERT, 64'h504, 1'b0, ALL_ONES, '0);
        issue_request(OP_INSERT, 64'h505, 1'b0, 64'd1, '0);
        // Clear the whole table in one sweep
        issue_request(OP_CLEANUP, '0, 1'b0, '0, '0);
    endtask

    // Mostly keys from a pool larger than the table so that hits, misses and
    // evictions all come often; the rest is fresh, zero or all-ones keys.
    // Time creeps forward, with rare jumps that make ages wrap.
    task automatic test_random_traffic(int count);
        int          n;
        int          r;
        op_t         op;
        logic [63:0] key;
        logic [63:0] max_age;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_INSERT;
            else if (r < 60)
                op = OP_ERASE;
            else if (r < 90)
                op = OP_QUERY;
            else
                op = OP_CLEANUP;

            r = $urandom_range(0, 99);
            if (r < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 92)
                key = {$urandom, $urandom};
            else if (r < 96)
                key = '0;
            else
                key = ALL_ONES;

            r = $urandom_range(0, 99);
            if (r < 2)
                clock_ms = {$urandom, $urandom};
            else if (r < 3)
                clock_ms = ALL_ONES - 64'($urandom_range(0, 100));
            else
                clock_ms = clock_ms + 64'($urandom_range(0, 20));

            r = $urandom_range(0, 99);
            if (op != OP_CLEANUP)
                max_age = {$urandom, $urandom};
            else if (r < 70)
                max_age = 64'($urandom_range(0, 400));
            else if (r < 80)
                max_age = '0;
            else if (r < 90)
                max_age = ALL_ONES;
            else
                max_age = {$urandom, $urandom};

            issue_request(op, key, 1'($urandom_range(0, 1)), clock_ms, max_age);
        end
    endtask

    initial
    begin : main
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_done[i]  = 1'b0;
            tbl_stamp[i] = '0;
        end
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0)
                key_pool[i] = 64'd1;
        end

        // Hold reset, then release it at a clock edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_zero_key();
        test_insert_query_erase();
        test_cleanup_ages();
        test_full_table();

        test_random_traffic(400);
        idle_on = 1'b0;
        test_random_traffic(250);
        idle_on = 1'b1;
        test_random_traffic(1000);

        s_tvalid <= 1'b0;

        // Drain outstanding responses, then allow one more sweep of slack
        while (expected_resps.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
